@@ rtl/core/ufrc_pkg.sv @@
// shared constants and controller/datapath interface types for the union-find engine
package ufrc_pkg;

    localparam int NODES_DEF = 1024;
    localparam int FIELD_W   = 10;
    localparam int RANK_W    = 4;
    localparam int CMD_W     = 2;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // command codes; the spare code behaves as a query
    localparam logic [CMD_W-1:0] CMD_UNION = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic red_step;
        logic walk_start;
        logic walk_step;
        logic comp_start;
        logic comp_step;
        logic opnd_b;
        logic link;
        logic bump;
        logic sweep_step;
        logic out_load;
        logic out_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic red_last;
        logic walk_done;
        logic comp_skip;
        logic comp_done;
        logic roots_eq;
        logic ranks_eq;
        logic sweep_last;
    } dp_stat_t;

endpackage

@@ rtl/core/ufrc_ram.sv @@
// generic single-write, single-read RAM with registered read data
module ufrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/ufrc_dp.sv @@
// datapath: node reduction, root walk, path compression, linking, table sweep, result register
module ufrc_dp #(
    parameter int NODES = ufrc_pkg::NODES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ufrc_pkg::dp_cmd_t                             ctl,
    output ufrc_pkg::dp_stat_t                            stat,
    input  logic [ufrc_pkg::FIELD_W-1:0]                  node_a,
    input  logic [ufrc_pkg::FIELD_W-1:0]                  node_b,
    output logic                                          ram_we,
    output logic [$clog2(NODES)-1:0]                      ram_waddr,
    output logic [$clog2(NODES)+ufrc_pkg::RANK_W-1:0]     ram_wdata,
    output logic [$clog2(NODES)-1:0]                      ram_raddr,
    input  logic [$clog2(NODES)+ufrc_pkg::RANK_W-1:0]     ram_rdata,
    output logic [ufrc_pkg::FIELD_W-1:0]                  root_a,
    output logic [ufrc_pkg::FIELD_W-1:0]                  root_b,
    output logic                                          same_set
);

    import ufrc_pkg::*;

    localparam int IDX_W  = $clog2(NODES);
    localparam int ENT_W  = IDX_W + RANK_W;
    localparam int RED_W  = IDX_W + FIELD_W;
    localparam int SHIFT  = FIELD_W + IDX_W;
    localparam int RCP_W  = FIELD_W + 2;
    localparam int PROD_W = FIELD_W + RCP_W;
    // rounded-up reciprocal of the node count, exact quotient for every 10-bit node number
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((longint'(1) << SHIFT) + longint'(NODES) - 1) / longint'(NODES));
    localparam logic [RED_W-1:0] NODES_V  = RED_W'(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    logic [FIELD_W-1:0] na_reg, na_next, nb_reg, nb_next;
    logic [FIELD_W-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic               red_ph_reg, red_ph_next;
    logic [IDX_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   top_reg, top_next;
    logic [IDX_W-1:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [RANK_W-1:0]  rank_a_reg, rank_a_next, rank_b_reg, rank_b_next;
    logic [FIELD_W-1:0] root_a_reg, root_a_next, root_b_reg, root_b_next;
    logic               same_reg, same_next;

    logic [IDX_W-1:0]   na_idx, nb_idx, start_idx, rd_par;
    logic [RANK_W-1:0]  rd_rank, rank_a_inc;
    logic [PROD_W-1:0]  prod_a, prod_b;
    logic [RED_W-1:0]   back_a, back_b;
    logic               found;

    assign na_idx    = IDX_W'(na_reg);
    assign nb_idx    = IDX_W'(nb_reg);
    assign start_idx = ctl.opnd_b ? nb_idx : na_idx;
    assign rd_par    = ram_rdata[IDX_W-1:0];
    assign rd_rank   = ram_rdata[ENT_W-1:IDX_W];
    assign found     = ctl.walk_step && (rd_par == cur_reg);
    assign rank_a_inc = (rank_a_reg == RANK_MAX) ? rank_a_reg : RANK_W'(rank_a_reg + 1'b1);

    assign prod_a = PROD_W'(na_reg) * PROD_W'(RCP);
    assign prod_b = PROD_W'(nb_reg) * PROD_W'(RCP);
    assign back_a = RED_W'(qa_reg) * NODES_V;
    assign back_b = RED_W'(qb_reg) * NODES_V;

    assign stat.red_last   = red_ph_reg;
    assign stat.walk_done  = (rd_par == cur_reg);
    assign stat.comp_skip  = (start_idx == top_reg);
    assign stat.comp_done  = (rd_par == top_reg);
    assign stat.roots_eq   = (ra_reg == rb_reg);
    assign stat.ranks_eq   = (rank_a_reg == rank_b_reg);
    assign stat.sweep_last = (sweep_cnt_reg == LAST_IDX);

    // node reduction in two steps: quotient by reciprocal multiply, then subtract back
    always_comb
    begin
        na_next     = na_reg;
        nb_next     = nb_reg;
        qa_next     = qa_reg;
        qb_next     = qb_reg;
        red_ph_next = red_ph_reg;
        if (ctl.load)
        begin
            na_next     = node_a;
            nb_next     = node_b;
            red_ph_next = 1'b0;
        end
        else if (ctl.red_step)
        begin
            if (!red_ph_reg)
            begin
                qa_next = FIELD_W'(prod_a >> SHIFT);
                qb_next = FIELD_W'(prod_b >> SHIFT);
            end
            else
            begin
                na_next = na_reg - back_a[FIELD_W-1:0];
                nb_next = nb_reg - back_b[FIELD_W-1:0];
            end
            red_ph_next = !red_ph_reg;
        end
    end

    // walk and compression address tracking
    always_comb
    begin
        cur_next    = cur_reg;
        top_next    = top_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        if (ctl.walk_start || ctl.comp_start)
        begin
            cur_next = start_idx;
        end
        else if (ctl.walk_step || ctl.comp_step)
        begin
            cur_next = rd_par;
        end
        if (found)
        begin
            top_next = cur_reg;
            if (ctl.opnd_b)
            begin
                rb_next     = cur_reg;
                rank_b_next = rd_rank;
            end
            else
            begin
                ra_next     = cur_reg;
                rank_a_next = rd_rank;
            end
        end
    end

    assign ram_raddr = (ctl.walk_start || ctl.comp_start) ? start_idx : rd_par;

    // table write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_cnt_reg;
        ram_wdata = {{RANK_W{1'b0}}, sweep_cnt_reg};
        priority if (ctl.sweep_step)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.comp_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_reg;
            ram_wdata = {rd_rank, top_reg};
        end
        else if (ctl.link)
        begin
            ram_we = 1'b1;
            if (rank_a_reg < rank_b_reg)
            begin
                ram_waddr = ra_reg;
                ram_wdata = {rank_a_reg, rb_reg};
            end
            else
            begin
                ram_waddr = rb_reg;
                ram_wdata = {rank_b_reg, ra_reg};
            end
        end
        else if (ctl.bump)
        begin
            ram_we    = 1'b1;
            ram_waddr = ra_reg;
            ram_wdata = {rank_a_inc, ra_reg};
        end
    end

    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (ctl.sweep_step)
        begin
            sweep_cnt_next = stat.sweep_last ? '0 : IDX_W'(sweep_cnt_reg + 1'b1);
        end
    end

    // result register
    always_comb
    begin
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        same_next   = same_reg;
        if (ctl.out_load)
        begin
            if (ctl.out_clear)
            begin
                root_a_next = '0;
                root_b_next = '0;
                same_next   = 1'b0;
            end
            else
            begin
                root_a_next = FIELD_W'(ra_reg);
                root_b_next = FIELD_W'(rb_reg);
                same_next   = stat.roots_eq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ph_reg    <= 1'b0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            red_ph_reg    <= red_ph_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        cur_reg    <= cur_next;
        top_reg    <= top_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        same_reg   <= same_next;
    end

    assign root_a   = root_a_reg;
    assign root_b   = root_b_reg;
    assign same_set = same_reg;

    a_red_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.red_step && stat.red_last |=>
            (RED_W'(na_reg) < RED_W'(NODES)) && (RED_W'(nb_reg) < RED_W'(NODES)))
        else $error("reduced node number not below node count");

    a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.comp_step |-> cur_reg != top_reg)
        else $error("compression write aimed at the root itself");

    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.link |-> ra_reg != rb_reg)
        else $error("link issued for roots that are already equal");

endmodule

@@ rtl/core/ufrc_ctrl.sv @@
// controller state machine: sequences reduction, both finds, linking, sweeps and result handoff
module ufrc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ufrc_pkg::CMD_W-1:0]     cmd,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ufrc_pkg::dp_cmd_t              ctl,
    input  ufrc_pkg::dp_stat_t             stat
);

    import ufrc_pkg::*;

    typedef enum logic [9:0] {
        ST_SWEEP  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_REDUCE = 10'b0000000100,
        ST_WSTART = 10'b0000001000,
        ST_WALK   = 10'b0000010000,
        ST_CSTART = 10'b0000100000,
        ST_COMP   = 10'b0001000000,
        ST_LINK   = 10'b0010000000,
        ST_BUMP   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   union_reg, union_next;
    logic   second_reg, second_next;
    logic   clr_reg, clr_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, find_end, out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        union_next  = union_reg;
        second_next = second_reg;
        clr_next    = clr_reg;
        ctl         = '0;
        ctl.opnd_b  = second_reg;
        find_end    = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = clr_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_CLEAR)
                    begin
                        clr_next   = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        ctl.load    = 1'b1;
                        union_next  = (cmd == CMD_UNION);
                        second_next = 1'b0;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                ctl.red_step = 1'b1;
                if (stat.red_last)
                begin
                    state_next = ST_WSTART;
                end
            end
            ST_WSTART:
            begin
                ctl.walk_start = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_CSTART;
                end
            end
            ST_CSTART:
            begin
                ctl.comp_start = 1'b1;
                if (stat.comp_skip)
                begin
                    find_end = 1'b1;
                end
                else
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                ctl.comp_step = 1'b1;
                if (stat.comp_done)
                begin
                    find_end = 1'b1;
                end
            end
            ST_LINK:
            begin
                ctl.link   = 1'b1;
                state_next = stat.ranks_eq ? ST_BUMP : ST_DONE;
            end
            ST_BUMP:
            begin
                ctl.bump   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.out_load  = 1'b1;
                    ctl.out_clear = clr_reg;
                    clr_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (find_end)
        begin
            if (!second_reg)
            begin
                second_next = 1'b1;
                state_next  = ST_WSTART;
            end
            else if (union_reg && !stat.roots_eq)
            begin
                state_next = ST_LINK;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            union_reg     <= 1'b0;
            second_reg    <= 1'b0;
            clr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            union_reg     <= union_next;
            second_reg    <= second_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while its transfer is pending");

    a_bump_after_link: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BUMP |-> $past(state_reg == ST_LINK))
        else $error("rank raised without a preceding link");

endmodule

@@ rtl/core/union_find_rank_compress.sv @@
// top level of the disjoint-set engine with union by rank and path compression
// Disjoint-set engine over NODES nodes, one item at a time. Each item (cmd, node_a, node_b) gives
// one result (root_a, root_b, same_set) with the roots as they stood before any merge. Node
// numbers are first reduced modulo NODES, a reciprocal multiply for the quotient and then
// a subtract of quotient times NODES. Each operand then walks up the parent table one entry
// per cycle through the single read port of the node RAM and is compressed in a second pass,
// again one entry per cycle, reading the next parent while the current entry is rewritten.
// The walk depths da and db of the two operands are each at most log2(NODES) under union by
// rank, and the compression pass rewrites the same da or db entries. An item's result is
// loaded only once the previous result has left the result register. Clear (cmd 2) and
// reset both run a sweep that rewrites every RAM entry while no input is taken; clear then
// reports zeros. Code 3 is treated as a query. The result register lets the next item start
// while a result waits for its transfer.
module union_find_rank_compress #(
    parameter int NODES = ufrc_pkg::NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ufrc_pkg::CMD_W-1:0]    cmd,
    input  logic [ufrc_pkg::FIELD_W-1:0]  node_a,
    input  logic [ufrc_pkg::FIELD_W-1:0]  node_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ufrc_pkg::FIELD_W-1:0]  root_a,
    output logic [ufrc_pkg::FIELD_W-1:0]  root_b,
    output logic                          same_set
);

    import ufrc_pkg::*;

    // one RAM entry holds a node's rank above its parent index
    localparam int IDX_W = $clog2(NODES);
    localparam int ENT_W = IDX_W + RANK_W;

    dp_cmd_t             ctl;
    dp_stat_t            stat;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    // sequencer: accepts items, drives the datapath step by step, owns the result valid
    ufrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl),
        .stat      (stat)
    );

    // reduction, walk, compression, link and sweep logic plus the result payload
    ufrc_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .node_a    (node_a),
        .node_b    (node_b),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .root_a    (root_a),
        .root_b    (root_b),
        .same_set  (same_set)
    );

    // combined parent and rank table
    ufrc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ verif/ufrc_scoreboard_pkg.sv @@
// disjoint-set predictor and result scoreboard for the union-find engine testbench
`timescale 1ns / 100ps

package ufrc_scoreboard_pkg;

    import ufrc_pkg::*;

    typedef logic [FIELD_W-1:0] node_t;
    typedef logic [CMD_W-1:0]   op_t;

    // spare code, handled as a query by the block
    localparam op_t CMD_SPARE = 2'd3;
    localparam int  SET_NODES = NODES_DEF;

    typedef struct {
        node_t root_a;
        node_t root_b;
        logic  same_set;
    } root_report_t;

    class dsu_scoreboard;

        int unsigned       parent_of [SET_NODES];
        logic [RANK_W-1:0] rank_of [SET_NODES];
        root_report_t      expected_roots [$];
        int                mismatches;

        function new();
            mismatches = 0;
            clear_sets();
        endfunction

        function void clear_sets();
            for (int i = 0; i < SET_NODES; i++)
            begin
                parent_of[i] = i;
                rank_of[i]   = '0;
            end
        endfunction

        // bounded walk to the root, then point every node on the path at it
        function int unsigned find_root(int unsigned start);
            int unsigned top;
            int unsigned cur;
            int unsigned up;
            int unsigned steps;
            top   = start;
            steps = 0;
            while (parent_of[top] != top && steps < SET_NODES)
            begin
                top = parent_of[top] % SET_NODES;
                steps++;
            end
            cur   = start;
            steps = 0;
            while (cur != top && steps < SET_NODES)
            begin
                up             = parent_of[cur] % SET_NODES;
                parent_of[cur] = top;
                cur            = up;
                steps++;
            end
            return top;
        endfunction

        function void note_item(op_t op, node_t a, node_t b);
            int unsigned  ra;
            int unsigned  rb;
            root_report_t r;
            if (op == CMD_CLEAR)
            begin
                clear_sets();
                r.root_a   = '0;
                r.root_b   = '0;
                r.same_set = 1'b0;
            end
            else
            begin
                ra         = find_root(a % SET_NODES);
                rb         = find_root(b % SET_NODES);
                r.root_a   = node_t'(ra);
                r.root_b   = node_t'(rb);
                r.same_set = (ra == rb);
                // union by rank, node_a's root wins a tie
                if (op == CMD_UNION && ra != rb)
                begin
                    if (rank_of[ra] < rank_of[rb])
                        parent_of[ra] = rb;
                    else if (rank_of[rb] < rank_of[ra])
                        parent_of[rb] = ra;
                    else
                    begin
                        parent_of[rb] = ra;
                        if (rank_of[ra] < RANK_MAX)
                            rank_of[ra]++;
                    end
                end
            end
            expected_roots.push_back(r);
        endfunction

        function void check_roots(node_t ra, node_t rb, logic same);
            root_report_t want;
            if (expected_roots.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, root_a %0d root_b %0d same_set %0b",
                         $time, ra, rb, same);
                mismatches++;
                return;
            end
            want = expected_roots.pop_front();
            if (ra !== want.root_a)
            begin
                $display("%0t: root_a expected %0d, got %0d", $time, want.root_a, ra);
                mismatches++;
            end
            if (rb !== want.root_b)
            begin
                $display("%0t: root_b expected %0d, got %0d", $time, want.root_b, rb);
                mismatches++;
            end
            if (same !== want.same_set)
            begin
                $display("%0t: same_set expected %0b, got %0b", $time, want.same_set, same);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_roots.size();
        endfunction

    endclass

endpackage

@@ verif/tb_union_find_rank_compress.sv @@
// top-level testbench for the union-find engine: stimulus, flow control and checking
`timescale 1ns / 100ps

module tb_union_find_rank_compress;

    import ufrc_pkg::*;
    import ufrc_scoreboard_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    // a clear sweep takes no input, so keep this well above the length of one sweep
    localparam int STUCK_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    // wait after the last expected result, so a stray extra result is still caught
    localparam int DRAIN_CYCLES = 100;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    op_t   cmd;
    node_t node_a;
    node_t node_b;
    logic  out_valid;
    logic  out_stall;
    node_t root_a;
    node_t root_b;
    logic  same_set;

    dsu_scoreboard sb;

    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // bumped by the stimulus to ask the receiver for a long hold-off
    int hold_tickets   = 0;
    int stuck_cycles   = 0;

    union_find_rank_compress dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root_a    (root_a),
        .root_b    (root_b),
        .same_set  (same_set)
    );

    always #5 clk = ~clk;

    // offer one item from the falling edge, with random idle cycles first, and hold it
    // until the rising edge that completes the transfer
    task automatic send_item(input op_t op, input node_t a, input node_t b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        node_a   <= a;
        node_b   <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(op, a, b);
        items_sent++;
    endtask

    // receiver: random stall, or a long hold-off on request so the block backs up
    initial
    begin
        int hold_left;
        int holds_served;
        out_stall    = 1'b0;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_tickets)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result monitor, sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_roots(root_a, root_b, same_set);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("union_find_rank_compress test failed");
            $finish;
        end
    end

    initial
    begin
        int    phase;
        int    pick;
        int    n;
        int    base;
        int    span;
        int    levels;
        int    pool;
        int    r;
        node_t a;
        node_t b;
        op_t   op;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_UNION;
        node_a   = '0;
        node_b   = '0;
        sb       = new();

        // first phase: sender idles lightly, receiver stalls heavily
        phase          = 1;
        send_idle_pct  = 20;
        recv_stall_pct = 74;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part: fresh roots at both ends of the range, same node twice
        send_item(CMD_QUERY, 10'd0, 10'd1023);
        send_item(CMD_UNION, 10'd0, 10'd0);
        // equal ranks: node_b's root goes under node_a's root
        send_item(CMD_UNION, 10'd1023, 10'd0);
        send_item(CMD_QUERY, 10'd0, 10'd1023);
        send_item(CMD_SPARE, 10'd1023, 10'd0);
        // lower rank on the node_a side
        send_item(CMD_UNION, 10'd5, 10'd1023);
        send_item(CMD_UNION, 10'd6, 10'd7);
        // equal nonzero ranks, deepens the tree under node 6
        send_item(CMD_UNION, 10'd6, 10'd1023);
        // lower rank on the node_a side against a deep tree, compresses node 0's path
        send_item(CMD_UNION, 10'd700, 10'd0);
        send_item(CMD_QUERY, 10'd5, 10'd7);
        send_item(CMD_UNION, 10'h2AA, 10'h155);
        send_item(CMD_QUERY, 10'h155, 10'h2AA);
        // clear with nonzero operands still reports zeros
        send_item(CMD_CLEAR, 10'd1023, 10'd1023);
        send_item(CMD_QUERY, 10'd0, 10'd1023);
        send_item(CMD_SPARE, 10'd512, 10'd511);
        send_item(CMD_CLEAR, 10'd0, 10'd0);

        // random part, in episodes
        while (items_sent < ITEM_TARGET)
        begin
            // switch flow-control phase by progress, each switch starts with a long hold-off
            if (items_sent >= 2 * ITEM_TARGET / 3 && phase < 3)
            begin
                phase          = 3;
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_tickets++;
            end
            else if (items_sent >= ITEM_TARGET / 3 && phase < 2)
            begin
                phase          = 2;
                send_idle_pct  = 74;
                recv_stall_pct = 20;
                hold_tickets++;
            end

            pick = $urandom_range(99);
            if (pick < 6)
                send_item(CMD_CLEAR, node_t'($urandom), node_t'($urandom));
            else if (pick < 18)
            begin
                // noise: any command, any nodes
                n = $urandom_range(5, 15);
                repeat (n)
                    send_item(op_t'($urandom_range(3)), node_t'($urandom_range(1023)),
                              node_t'($urandom_range(1023)));
            end
            else if (pick < 40)
            begin
                // pairwise build of a balanced tree over a window, giving deep root walks,
                // then queries across the window
                base   = $urandom_range(1023);
                levels = $urandom_range(2, 6);
                span   = 1 << levels;
                for (int k = 0; k < levels; k++)
                begin
                    for (int i = 0; i < span; i += (2 << k))
                    begin
                        a = node_t'(base + i);
                        b = node_t'(base + i + (1 << k));
                        if ($urandom_range(3) == 0)
                            send_item(CMD_UNION, b, a);
                        else
                            send_item(CMD_UNION, a, b);
                    end
                end
                repeat (span / 2)
                begin
                    op = ($urandom_range(4) == 0) ? CMD_SPARE : CMD_QUERY;
                    send_item(op, node_t'(base + $urandom_range(span - 1)),
                              node_t'(base + $urandom_range(span - 1)));
                end
            end
            else
            begin
                // mixed unions and queries inside a small window, windows may wrap
                base = $urandom_range(1023);
                pool = $urandom_range(4, 64);
                n    = $urandom_range(10, 40);
                repeat (n)
                begin
                    r  = $urandom_range(99);
                    op = (r < 55) ? CMD_UNION : ((r < 90) ? CMD_QUERY : CMD_SPARE);
                    send_item(op, node_t'(base + $urandom_range(pool - 1)),
                              node_t'(base + $urandom_range(pool - 1)));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, the watchdog covers a hang here
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("union_find_rank_compress test passed");
        else
            $display("union_find_rank_compress test failed");
        $finish;
    end

endmodule

@@ union_find_rank_compress.f @@
rtl/core/ufrc_pkg.sv
rtl/core/ufrc_ram.sv
rtl/core/ufrc_dp.sv
rtl/core/ufrc_ctrl.sv
rtl/core/union_find_rank_compress.sv
verif/ufrc_scoreboard_pkg.sv
verif/tb_union_find_rank_compress.sv
